FILE: sv/uartrb_pkg.sv
// Shared operation codes and result record for the receive ring buffer.
`timescale 1ns / 1ps

package uartrb_pkg;

  // Operation codes carried on the mode field
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_PEEK   = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // Width of the configurable free-space threshold
  localparam int ThreshW = 9;

  // Reset value of the free-space threshold
  localparam logic [ThreshW-1:0] THRESH_RESET = 9'd16;

  // Result fields held in the output register (peek data comes from the store)
  typedef struct packed {
    logic       read_valid;
    logic [7:0] fill_count;
    logic       rts_enabled;
    logic       overwrote;
  } result_t;

endpackage

FILE: sv/uartrb_store.sv
// Byte store of the receive ring buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module uartrb_store #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  // Write a received byte at the tail slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read for a peek; hold the data until the next peek
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/uart_rx_ring_buffer_flow_control_core.sv
// Top level of the UART receive ring buffer with RTS flow control.
//
// Requests arrive on in_valid/in_ready with fields mode, rx_byte, offset and
// delete_count; mode selects push (store rx_byte), peek (read the byte offset
// places after the oldest) or delete (drop up to delete_count oldest bytes).
// Every request gives exactly one result on out_valid/out_ready: read_byte,
// read_valid, fill_count, rts_enabled and overwrote.
// The buffer holds up to DEPTH-1 bytes; a push into a full buffer discards the
// oldest byte and flags overwrote. RTS drops after a push that leaves free
// space at or below flow_threshold and rises after a delete that leaves it at
// or above. flow_threshold is written through flow_threshold_we/_wdata; the
// user must write it only while the block is idle; the block does not enforce
// this. out_valid rises in the cycle after acceptance. The block takes one
// request per cycle while out_ready is high; the byte store has a single write
// port and a single registered read port, and pointers, count and RTS state
// update at acceptance. Reset clears pointers, count, RTS (enabled), threshold
// (16) and out_valid; stored bytes are not cleared. When the receiver holds
// out_ready low the result register keeps its request and in_ready falls until
// the result is taken.
`timescale 1ns / 1ps

module uart_rx_ring_buffer_flow_control_core #(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] rx_byte,
  input  logic [7:0] offset,
  input  logic [8:0] delete_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_byte,
  output logic       read_valid,
  output logic [7:0] fill_count,
  output logic       rts_enabled,
  output logic       overwrote,
  input  logic       flow_threshold_we,
  input  logic [8:0] flow_threshold_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW + 1 > uartrb_pkg::ThreshW) ? AW + 1 : uartrb_pkg::ThreshW;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0]                 head;
  logic [AW-1:0]                 head_next;
  logic [AW-1:0]                 tail;
  logic [AW-1:0]                 tail_next;
  logic [AW-1:0]                 held;
  logic [AW-1:0]                 held_next;
  logic                          rts_dropped;
  logic                          rts_dropped_next;
  logic [uartrb_pkg::ThreshW-1:0] flow_threshold;

  logic                 in_fire;
  logic [CW-1:0]        held_x;
  logic [CW-1:0]        head_x;
  logic [CW-1:0]        off_x;
  logic [CW-1:0]        del_x;
  logic [CW-1:0]        thr_x;
  logic                 peek_hit;
  logic [CW-1:0]        peek_sum;
  logic [AW-1:0]        peek_addr;
  logic [AW-1:0]        tail_inc;
  logic                 push_full;
  logic [CW-1:0]        del_n;
  logic [CW-1:0]        del_sum;
  logic [CW-1:0]        held_new_x;
  logic [CW-1:0]        free_x;
  logic                 wr_en;
  logic                 rd_en;
  logic [7:0]           rd_data;

  uartrb_pkg::result_t  res_next;
  uartrb_pkg::result_t  res;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Widen operands to a common compare width
  assign held_x = CW'(held);
  assign head_x = CW'(head);
  assign off_x  = CW'(offset);
  assign del_x  = CW'(delete_count);
  assign thr_x  = CW'(flow_threshold);

  // Peek address: head plus offset, wrapped once
  assign peek_hit  = off_x < held_x;
  assign peek_sum  = head_x + off_x;
  assign peek_addr = !peek_hit ? '0 :
                     (peek_sum >= DEPTH_C) ? AW'(peek_sum - DEPTH_C) : AW'(peek_sum);

  // Push: advance the tail, detect a full buffer
  assign tail_inc  = (tail == LAST_IDX) ? '0 : tail + AW'(1);
  assign push_full = (tail_inc == head);

  // Delete: clamp the count and advance the head
  assign del_n   = (del_x < held_x) ? del_x : held_x;
  assign del_sum = head_x + del_n;

  // Work out the next state and the result of this request
  always_comb begin
    head_next        = head;
    tail_next        = tail;
    held_next        = held;
    rts_dropped_next = rts_dropped;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    res_next         = '0;
    held_new_x       = held_x;
    free_x           = '0;
    unique case (uartrb_pkg::mode_t'(mode))
      uartrb_pkg::MODE_PUSH: begin
        wr_en     = in_fire;
        tail_next = tail_inc;
        if (push_full) begin
          head_next          = (head == LAST_IDX) ? '0 : head + AW'(1);
          res_next.overwrote = 1'b1;
        end else begin
          held_next  = held + AW'(1);
          held_new_x = held_x + CW'(1);
        end
        free_x = DEPTH_C - held_new_x;
        if (free_x <= thr_x) begin
          rts_dropped_next = 1'b1;
        end
      end
      uartrb_pkg::MODE_PEEK: begin
        rd_en               = in_fire && peek_hit;
        res_next.read_valid = peek_hit;
      end
      uartrb_pkg::MODE_DELETE: begin
        head_next  = (del_sum >= DEPTH_C) ? AW'(del_sum - DEPTH_C) : AW'(del_sum);
        held_new_x = held_x - del_n;
        held_next  = AW'(held_new_x);
        free_x     = DEPTH_C - held_new_x;
        if (free_x >= thr_x) begin
          rts_dropped_next = 1'b0;
        end
      end
      uartrb_pkg::MODE_NOP: begin
        // no change to the buffer
      end
      default: begin
        // unreachable with a two-bit code
      end
    endcase
    res_next.fill_count  = held_new_x[7:0];
    res_next.rts_enabled = !rts_dropped_next;
  end

  // Update pointers, count and RTS state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      held        <= '0;
      rts_dropped <= 1'b0;
    end else if (in_fire) begin
      head        <= head_next;
      tail        <= tail_next;
      held        <= held_next;
      rts_dropped <= rts_dropped_next;
    end
  end

  // Hold the free-space threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_threshold <= uartrb_pkg::THRESH_RESET;
    end else if (flow_threshold_we) begin
      flow_threshold <= flow_threshold_wdata;
    end
  end

  // Byte store
  uartrb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (peek_addr),
    .rd_data (rd_data)
  );

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign read_byte   = res.read_valid ? rd_data : 8'd0;
  assign read_valid  = res.read_valid;
  assign fill_count  = res.fill_count;
  assign rts_enabled = res.rts_enabled;
  assign overwrote   = res.overwrote;

endmodule

FILE: sv/uartrb_chk.sv
// Port-level checks for the receive ring buffer, bound to the top level.
`timescale 1ns / 1ps

module uartrb_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_byte,
  input logic       read_valid,
  input logic [7:0] fill_count,
  input logic       rts_enabled,
  input logic       overwrote
);

  // A peek result never also reports an overwrite
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_valid && overwrote))
    else $error("read_valid and overwrote both set");

  // Data only accompanies a valid peek
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !read_valid) |-> (read_byte == 8'd0))
    else $error("read_byte nonzero without read_valid");

  // No result straight after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

  // An accepted request gives a result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request gave no result");

  // A stalled result keeps its fill_count, rts_enabled and read_byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(fill_count) && $stable(rts_enabled) && $stable(read_byte)))
    else $error("stalled result changed");

endmodule

bind uart_rx_ring_buffer_flow_control_core uartrb_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .read_byte   (read_byte),
  .read_valid  (read_valid),
  .fill_count  (fill_count),
  .rts_enabled (rts_enabled),
  .overwrote   (overwrote)
);
